FILE: src/sliding_range_pair_max_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding range pair max block
// Clocked assertion forms with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef SLIDING_RANGE_PAIR_MAX_TOP_ASSERT_SVH
`define SLIDING_RANGE_PAIR_MAX_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SRPM_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define SRPM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRPM_ASSERT_RST(label, clk, rst, prop, msg)

`define SRPM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: src/srpm_pkg.sv
// ----------------------------------------------------------------------------
// srpm_pkg
// Shared constants and sequencer state type for the sliding range pair max.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srpm_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 1024;
   localparam int COORD_BITS_DEFAULT  = 28;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRONT_RD,
      ST_FRONT_CHK,
      ST_CAND,
      ST_BEST,
      ST_BACK_RD,
      ST_BACK_CHK,
      ST_PUSH
   } srpm_state_type;

endpackage

FILE: src/srpm_ram.sv
// ----------------------------------------------------------------------------
// srpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/srpm_alu.sv
// ----------------------------------------------------------------------------
// srpm_alu
// Shared add / subtract unit with a greater-than-zero flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpm_alu #(
   parameter int WIDTH = 31
) (
   input  logic signed [WIDTH-1:0] op_a,
   input  logic signed [WIDTH-1:0] op_b,
   input  logic                    op_sub,
   output logic signed [WIDTH-1:0] result,
   output logic                    positive
);

   logic [WIDTH-1:0] b_term;

   assign b_term   = op_sub ? ~op_b : op_b;
   assign result   = op_a + b_term + WIDTH'(op_sub);
   assign positive = ~result[WIDTH-1] & (|result);

endmodule

FILE: src/sliding_range_pair_max_top.sv
// ----------------------------------------------------------------------------
// sliding_range_pair_max_top
// Streaming best pair score y_i + y_j + x_j - x_i within an x window.
// ----------------------------------------------------------------------------
// Usage:
//   csr_wr_en / csr_wr_data set the window range; write only while idle.
//   Requests (x, y, last) enter on req_valid / req_stall, one at a time;
//   req_stall is high while a request is in progress.
//   Each request gives one response on rsp_valid / rsp_stall, held in an
//   output register, so the next request may enter while it waits.
//   Each request steps through front reads and checks, dropping entries out
//   of the window; a candidate and best update when a front entry is left
//   to pair with; back reads and checks, dropping dominated entries; then
//   the push. Each store access is a read step and a check step on the single
//   read port, and their compares and adds use the one shared add / subtract unit.
//   Amortized over a set, each point is pushed and dropped at most once.
//   A finished request waits in its last step while an earlier response
//   is still stalled.
//   Reset clears pointers, count, flags, running best and window range;
//   the store itself is not cleared. A request marked last clears the
//   set state once its response is captured.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_range_pair_max_top #(
   parameter int QUEUE_DEPTH = srpm_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COORD_BITS  = srpm_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [COORD_BITS-1:0]        csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS+1:0] rsp_best_value,
   output logic                         rsp_found,
   output logic                         rsp_overflow,
   output logic                         rsp_last_out
);

`include "sliding_range_pair_max_top_assert.svh"

   localparam int W  = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int EW = COORD_BITS + 2;
   localparam int AW = COORD_BITS + 3;
   localparam int MW = 2 * COORD_BITS + 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   srpm_pkg::srpm_state_type state_ff, state_in;

   logic [W-1:0]         range_ff;
   logic signed [W-1:0]  x_ff;
   logic signed [DW-1:0] d_ff;
   logic signed [DW-1:0] s_ff;
   logic signed [EW-1:0] xk_ff;
   logic                 last_ff;
   logic signed [EW-1:0] cand_ff;
   logic signed [EW-1:0] best_ff;
   logic                 found_ff;
   logic                 ovf_ff;
   logic [PW-1:0]        head_ff;
   logic [PW-1:0]        tail_ff;
   logic [CW-1:0]        count_ff;

   logic                 rsp_valid_ff;
   logic signed [EW-1:0] rsp_best_ff;
   logic                 rsp_found_ff;
   logic                 rsp_ovf_ff;
   logic                 rsp_last_ff;

   logic                 req_take;
   logic                 out_free;
   logic                 rsp_load;
   logic                 is_empty;
   logic                 is_full;
   logic [PW-1:0]        head_next;
   logic [PW-1:0]        tail_next;
   logic [PW-1:0]        tail_prev;

   logic                 mem_we;
   logic                 mem_re;
   logic [PW-1:0]        mem_raddr;
   logic [MW-1:0]        mem_wdata;
   logic [MW-1:0]        mem_rdata;
   logic signed [DW-1:0] rd_diff;
   logic signed [W-1:0]  rd_x;

   logic signed [AW-1:0] alu_a;
   logic signed [AW-1:0] alu_b;
   logic                 alu_sub;
   logic signed [AW-1:0] alu_res;
   logic                 alu_pos;

   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_load  = (state_ff == srpm_pkg::ST_PUSH) & out_free;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CW'(QUEUE_DEPTH));
   assign head_next = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? PW'(QUEUE_DEPTH - 1) : tail_ff - 1'b1;
   assign rd_diff   = mem_rdata[MW-1:W];
   assign rd_x      = mem_rdata[W-1:0];
   assign mem_wdata = {d_ff, x_ff};

   srpm_ram #(
      .WIDTH (MW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (tail_ff),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   srpm_alu #(
      .WIDTH (AW)
   ) u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .op_sub   (alu_sub),
      .result   (alu_res),
      .positive (alu_pos)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srpm_pkg::ST_IDLE: begin
            if (req_valid) state_in = srpm_pkg::ST_FRONT_RD;
         end
         srpm_pkg::ST_FRONT_RD: begin
            state_in = is_empty ? srpm_pkg::ST_BACK_RD : srpm_pkg::ST_FRONT_CHK;
         end
         srpm_pkg::ST_FRONT_CHK: begin
            state_in = alu_pos ? srpm_pkg::ST_FRONT_RD : srpm_pkg::ST_CAND;
         end
         srpm_pkg::ST_CAND: begin
            state_in = srpm_pkg::ST_BEST;
         end
         srpm_pkg::ST_BEST: begin
            state_in = srpm_pkg::ST_BACK_RD;
         end
         srpm_pkg::ST_BACK_RD: begin
            state_in = is_empty ? srpm_pkg::ST_PUSH : srpm_pkg::ST_BACK_CHK;
         end
         srpm_pkg::ST_BACK_CHK: begin
            state_in = alu_pos ? srpm_pkg::ST_PUSH : srpm_pkg::ST_BACK_RD;
         end
         srpm_pkg::ST_PUSH: begin
            if (out_free) state_in = srpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = srpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = head_ff;
      alu_a     = '0;
      alu_b     = '0;
      alu_sub   = 1'b0;
      case (state_ff)
         srpm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         srpm_pkg::ST_FRONT_RD: begin
            mem_re    = ~is_empty;
            mem_raddr = head_ff;
         end
         srpm_pkg::ST_FRONT_CHK: begin
            alu_a   = AW'(xk_ff);
            alu_b   = AW'(rd_x);
            alu_sub = 1'b1;
         end
         srpm_pkg::ST_CAND: begin
            alu_a   = AW'(s_ff);
            alu_b   = AW'(rd_diff);
            alu_sub = 1'b0;
         end
         srpm_pkg::ST_BEST: begin
            alu_a   = AW'(cand_ff);
            alu_b   = AW'(best_ff);
            alu_sub = 1'b1;
         end
         srpm_pkg::ST_BACK_RD: begin
            mem_re    = ~is_empty;
            mem_raddr = tail_prev;
         end
         srpm_pkg::ST_BACK_CHK: begin
            alu_a   = AW'(rd_diff);
            alu_b   = AW'(d_ff);
            alu_sub = 1'b1;
         end
         srpm_pkg::ST_PUSH: begin
            mem_we = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '0;
      end else if (csr_wr_en) begin
         range_ff <= csr_wr_data;
      end
   end

   // capture the request and its derived terms, and the candidate score
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff    <= req_x_coord;
         d_ff    <= DW'(req_y_coord) - DW'(req_x_coord);
         s_ff    <= DW'(req_y_coord) + DW'(req_x_coord);
         xk_ff   <= EW'(req_x_coord) - EW'(range_ff);
         last_ff <= req_last;
      end
      if (state_ff == srpm_pkg::ST_CAND) begin
         cand_ff <= alu_res[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         best_ff  <= '0;
         found_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         case (state_ff)
            srpm_pkg::ST_FRONT_CHK: begin
               if (alu_pos) begin
                  head_ff  <= head_next;
                  count_ff <= count_ff - 1'b1;
               end
            end
            srpm_pkg::ST_BEST: begin
               if (!found_ff || alu_pos) best_ff <= cand_ff;
               found_ff <= 1'b1;
            end
            srpm_pkg::ST_BACK_CHK: begin
               if (!alu_pos) begin
                  tail_ff  <= tail_prev;
                  count_ff <= count_ff - 1'b1;
               end
            end
            srpm_pkg::ST_PUSH: begin
               if (out_free) begin
                  if (last_ff) begin
                     head_ff  <= '0;
                     tail_ff  <= '0;
                     count_ff <= '0;
                     best_ff  <= '0;
                     found_ff <= 1'b0;
                     ovf_ff   <= 1'b0;
                  end else begin
                     tail_ff <= tail_next;
                     if (is_full) begin
                        head_ff <= head_next;
                        ovf_ff  <= 1'b1;
                     end else begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               head_ff <= head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == srpm_pkg::ST_PUSH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == srpm_pkg::ST_PUSH && out_free) begin
         rsp_best_ff  <= best_ff;
         rsp_found_ff <= found_ff;
         rsp_ovf_ff   <= ovf_ff | is_full;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_value = rsp_best_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign rsp_last_out   = rsp_last_ff;

   `SRPM_ASSERT_RST(a_count_bound, clock, reset, count_ff <= CW'(QUEUE_DEPTH), "count too big")
   `SRPM_ASSERT_RST(a_empty_ptrs, clock, reset, is_empty |-> (head_ff == tail_ff), "split pointers")
   `SRPM_ASSERT_ALWAYS(a_port_excl, clock, !(mem_we && mem_re), "store read and write together")
   `SRPM_ASSERT_RST(a_rsp_load, clock, reset, rsp_load |=> rsp_valid_ff, "response not loaded")
   `SRPM_ASSERT_RST(a_best_zero, clock, reset, !found_ff |-> (best_ff == '0), "best without pair")

endmodule

FILE: bench/srpm_pair_checker.sv
// ----------------------------------------------------------------------------
// srpm_pair_checker
// Watches both channels and the window range port of the sliding range pair
// max block, predicts each response from the accepted requests with its own
// deque model, and compares every accepted response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srpm_pair_checker #(
   parameter int QUEUE_DEPTH = 1024,
   parameter int COORD_BITS  = 28
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [COORD_BITS-1:0]        csr_wr_data,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   input  logic                         req_last,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [COORD_BITS+1:0] rsp_best_value,
   input  logic                         rsp_found,
   input  logic                         rsp_overflow,
   input  logic                         rsp_last_out,
   output int                           fail_count,
   output int                           outstanding
);

   typedef struct {
      logic signed [63:0] diag;
      logic signed [63:0] xpos;
   } window_entry_type;

   typedef struct {
      logic signed [COORD_BITS+1:0] best;
      logic                         found;
      logic                         overflow;
      logic                         last;
   } pair_result_type;

   window_entry_type   window_q[$];
   pair_result_type    pair_results_due[$];
   logic signed [63:0] window_range;
   logic signed [63:0] running_best;
   bit                 found_pair;
   bit                 dropped_oldest;

   task automatic clear_window();
      window_q.delete();
      running_best   = '0;
      found_pair     = 1'b0;
      dropped_oldest = 1'b0;
   endtask

   task automatic fold_point(input logic signed [63:0] xv, input logic signed [63:0] yv,
                             input logic lastv);
      logic signed [63:0] cand;
      window_entry_type   item;
      pair_result_type    res;
      item.diag = yv - xv;
      item.xpos = xv;
      while (window_q.size() > 0 && xv - window_q[0].xpos > window_range)
         window_q.delete(0);
      if (window_q.size() > 0) begin
         cand = xv + yv + window_q[0].diag;
         if (!found_pair || cand > running_best)
            running_best = cand;
         found_pair = 1'b1;
      end
      while (window_q.size() > 0 && window_q[$].diag <= item.diag)
         window_q.delete(window_q.size() - 1);
      if (window_q.size() >= QUEUE_DEPTH) begin
         window_q.delete(0);
         dropped_oldest = 1'b1;
      end
      window_q.insert(window_q.size(), item);
      res.best     = found_pair ? running_best[COORD_BITS+1:0] : '0;
      res.found    = found_pair;
      res.overflow = dropped_oldest;
      res.last     = lastv;
      pair_results_due.insert(pair_results_due.size(), res);
      if (lastv)
         clear_window();
   endtask

   function automatic bit field_ok(input string name, input logic signed [63:0] want,
                                   input logic signed [63:0] got);
      if (got === want)
         return 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      pair_result_type due;
      if (reset) begin
         clear_window();
         pair_results_due.delete();
         window_range = '0;
      end else begin
         if (csr_wr_en)
            window_range = 64'(csr_wr_data);
         if (rsp_valid && !rsp_stall) begin
            if (pair_results_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d %b %b %b",
                        $time, rsp_best_value, rsp_found, rsp_overflow, rsp_last_out);
               fail_count++;
            end else begin
               due = pair_results_due[0];
               pair_results_due.delete(0);
               if (!(field_ok("best_value", 64'(due.best), 64'(rsp_best_value))
                     & field_ok("found", 64'(due.found), 64'(rsp_found))
                     & field_ok("overflow", 64'(due.overflow), 64'(rsp_overflow))
                     & field_ok("last_out", 64'(due.last), 64'(rsp_last_out))))
                  fail_count++;
            end
         end
         if (req_valid && !req_stall)
            fold_point(64'(req_x_coord), 64'(req_y_coord), req_last);
      end
      outstanding = pair_results_due.size();
   end

endmodule

FILE: bench/tb_sliding_range_pair_max_top.sv
// ----------------------------------------------------------------------------
// tb_sliding_range_pair_max_top
// Drives point requests into the sliding range pair max block under several
// window ranges: a directed opening, then random point sets with windowing
// and dominance drops. Both sides idle at random and the response side holds
// off for long stretches; the checker beside the block predicts and compares
// every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sliding_range_pair_max_top;

   localparam int              CW            = srpm_pkg::COORD_BITS_DEFAULT;
   localparam int              DEPTH         = srpm_pkg::QUEUE_DEPTH_DEFAULT;
   localparam longint          X_MIN         = -(longint'(1) <<< (CW - 1));
   localparam longint          X_MAX         = (longint'(1) <<< (CW - 1)) - 1;
   localparam logic [CW-1:0]   RANGE_MAX     = '1;
   localparam int              RANDOM_POINTS = 860;
   localparam int              HOLD_CYCLES   = 300;
   localparam int              WIN_Y [7]     = '{10, 2, 8, -4, 0, 20, -1};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CW-1:0]         csr_wr_data = '0;
   logic                  req_valid   = 1'b0;
   logic signed [CW-1:0]  req_x_coord = '0;
   logic signed [CW-1:0]  req_y_coord = '0;
   logic                  req_last    = 1'b0;
   logic                  rsp_stall   = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic signed [CW+1:0]  rsp_best_value;
   logic                  rsp_found;
   logic                  rsp_overflow;
   logic                  rsp_last_out;
   int                    fail_count;
   int                    outstanding;
   int                    sent_points;
   bit                    steady_tx;
   bit                    steady_rx;
   bit                    hold_off;

   always #1 clock = ~clock;

   sliding_range_pair_max_top uut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_value (rsp_best_value),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_out   (rsp_last_out)
   );

   srpm_pair_checker #(
      .QUEUE_DEPTH (DEPTH),
      .COORD_BITS  (CW)
   ) pair_watch (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_value (rsp_best_value),
      .rsp_found      (rsp_found),
      .rsp_overflow   (rsp_overflow),
      .rsp_last_out   (rsp_last_out),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   function automatic int pick_gap(input bit steady);
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // enter and leave at a falling edge
   task automatic send_point(input longint xv, input longint yv, input bit lv);
      int gap;
      gap = pick_gap(steady_tx);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= xv[CW-1:0];
      req_y_coord <= yv[CW-1:0];
      req_last    <= lv;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_points++;
   endtask

   task automatic set_range(input logic [CW-1:0] value);
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_set(input int len, input longint step_max, input bit wide_y);
      longint xv;
      longint yv;
      longint slack;
      bit     lv;
      slack = X_MAX - X_MIN - longint'(len) * step_max;
      xv = X_MIN + longint'($urandom_range(0, 32'(slack)));
      for (int i = 0; i < len; i++) begin
         if (wide_y)
            yv = X_MIN + longint'($urandom_range(0, 32'(X_MAX - X_MIN)));
         else
            yv = longint'($urandom_range(0, 400)) - 200;
         lv = (i == len - 1) && ($urandom_range(0, 9) != 0);
         // occasional out-of-order x
         if ($urandom_range(0, 99) < 4)
            send_point(X_MIN + longint'($urandom_range(0, 32'(X_MAX - X_MIN))), yv, lv);
         else
            send_point(xv, yv, lv);
         xv += longint'($urandom_range(1, 32'(step_max)));
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (hold_off) begin
            hold_off   = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (!steady_rx && $urandom_range(0, 99) < 3) begin
            stall_left = $urandom_range(4, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady_rx && ($urandom_range(0, 99) < 25);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("sliding_range_pair_max_top verification failed");
      $finish;
   end

   initial begin
      longint        step;
      logic [CW-1:0] rng;
      int            base;
      int            phase;
      int            len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_range(RANGE_MAX);
      send_point(X_MIN, X_MIN, 1'b0);
      send_point(X_MAX, X_MAX, 1'b0);
      send_point(0, X_MIN, 1'b0);
      send_point(1, 1, 1'b0);
      send_point(2, 2, 1'b0);
      send_point(-5, 100, 1'b1);
      set_range('0);
      send_point(0, 0, 1'b0);
      send_point(1, 5, 1'b0);
      send_point(2, -3, 1'b0);
      send_point(1, 7, 1'b0);
      send_point(2, 2, 1'b1);
      set_range(CW'(3));
      for (int i = 0; i < 7; i++)
         send_point(longint'(i), longint'(WIN_Y[i]), i == 6);
      send_point(0, 0, 1'b1);

      base  = sent_points;
      phase = 0;
      while (sent_points < base + RANDOM_POINTS) begin
         case (phase < 4 ? phase : $urandom_range(0, 3))
            0: rng = RANGE_MAX;
            1: rng = '0;
            2: rng = CW'($urandom_range(1, 64));
            default: rng = CW'($urandom());
         endcase
         set_range(rng);
         steady_tx = ($urandom_range(0, 5) == 0);
         steady_rx = ($urandom_range(0, 5) == 0);
         if (phase == 1 || phase == 15)
            hold_off = 1'b1;
         repeat ($urandom_range(1, 4)) begin
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
               step = (longint'(1) <<< (CW - 1)) / len;
            else
               step = longint'($urandom_range(1, 8));
            run_set(len, step, $urandom_range(0, 1) != 0);
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("sliding_range_pair_max_top verification clean");
      else
         $display("sliding_range_pair_max_top verification failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/srpm_pkg.sv
src/srpm_ram.sv
src/srpm_alu.sv
src/sliding_range_pair_max_top.sv
bench/srpm_pair_checker.sv
bench/tb_sliding_range_pair_max_top.sv
